// ===== design/midi_sysex_command_parser_defines.svh =====
// Assertion macros for the SysEx command parser.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef MIDI_SYSEX_COMMAND_PARSER_DEFINES_SVH
`define MIDI_SYSEX_COMMAND_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define MSX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MSX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSX_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/msx_pkg.sv =====
// Shared types and constants of the SysEx command parser.
// No dependencies; used by the channel interfaces and the top level.
package msx_pkg;

    localparam int PATCH_BYTES = 256;
    localparam int COUNT_MAX   = PATCH_BYTES + 2;
    localparam int COUNT_W     = $clog2(COUNT_MAX + 1);

    localparam logic [7:0] HDR_BYTES [5] = '{8'hf0, 8'h00, 8'h00, 8'h7e, 8'h48};
    localparam logic [2:0] HDR_LEN       = 3'd5;
    localparam logic [7:0] SYSEX_END     = 8'hf7;

    localparam logic [6:0] CMD_READ  = 7'h01;
    localparam logic [6:0] CMD_WRITE = 7'h02;
    localparam logic [6:0] CMD_PING  = 7'h0f;

    localparam logic [1:0] EV_WRITE = 2'd0;
    localparam logic [1:0] EV_REPLY = 2'd1;
    localparam logic [1:0] EV_DUMP  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FEW     = 3'd1;
    localparam logic [2:0] ST_MANY    = 3'd2;
    localparam logic [2:0] ST_CSUM    = 3'd3;
    localparam logic [2:0] ST_NOSTORE = 3'd4;
    localparam logic [2:0] ST_BADCMD  = 3'd5;

    localparam logic CFG_DEVICE_ID   = 1'b0;
    localparam logic CFG_STORE_READY = 1'b1;

    typedef struct packed {
        logic [7:0] source_port;
        logic [7:0] midi_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] write_address;
        logic [6:0] write_data;
        logic [2:0] reply_status;
        logic [6:0] patch_number;
        logic [7:0] reply_port;
    } out_item_t;

endpackage

// ===== design/msx_in_if.sv =====
// Valid/ready channel carrying tagged MIDI bytes into the parser.
// Depends on msx_pkg for the payload type.
interface msx_in_if import msx_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/msx_out_if.sv =====
// Valid/ready channel carrying parser events (writes, replies, dump requests).
// Depends on msx_pkg for the payload type.
interface msx_out_if import msx_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/midi_sysex_command_parser.sv =====
// SysEx command parser top level: header match, port lock, command decode.
// Depends on msx_pkg, msx_in_if, msx_out_if and the assertion macro header.
//
// Usage:
//   byte_stream  - sink channel, one MIDI byte per transfer with its source port.
//   event_stream - source channel, at most one event per accepted byte:
//                  a patch memory write, a status reply or a dump request.
//   cfg_we/cfg_index/cfg_data - register writes (0 device id, 1 store ready),
//                  taken whenever cfg_we is high; user must write only while idle, unchecked by the block.
// Latency: an event appears on event_stream the cycle after its byte transfer.
// Throughput: one byte per cycle unless event_stream stalls; the single result register sets the figure.
// Stall: the result register holds while event_stream is stalled, and
//   byte_stream.ready stays low until that event is taken.
// Reset: all message state clears, device id goes to 0, store ready to 1,
//   and the result register empties.
`include "midi_sysex_command_parser_defines.svh"

module midi_sysex_command_parser import msx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    msx_in_if.sink      byte_stream,
    msx_out_if.source   event_stream
);

    logic [6:0]         device_id_reg;
    logic               store_ready_reg;

    logic               in_message_reg,   in_message_next;
    logic [2:0]         header_count_reg, header_count_next;
    logic               have_command_reg, have_command_next;
    logic [6:0]         command_code_reg, command_code_next;
    logic               have_patch_reg,   have_patch_next;
    logic [6:0]         patch_held_reg,   patch_held_next;
    logic [7:0]         locked_port_reg,  locked_port_next;
    logic [6:0]         running_sum_reg,  running_sum_next;
    logic [COUNT_W-1:0] byte_count_reg,   byte_count_next;
    logic [6:0]         sent_checksum_reg, sent_checksum_next;

    logic               out_valid_reg,    out_valid_next;
    out_item_t          out_data_reg,     out_data_next;

    logic               accept;
    logic               emit;
    out_item_t          item;
    logic [7:0]         port;
    logic [7:0]         b;
    logic [7:0]         expected;
    logic [6:0]         csum_expected;

    assign byte_stream.ready  = !out_valid_reg || event_stream.ready;
    assign accept             = byte_stream.valid && byte_stream.ready;
    assign event_stream.valid = out_valid_reg;
    assign event_stream.data  = out_data_reg;

    assign port          = byte_stream.data.source_port;
    assign b             = byte_stream.data.midi_byte;
    assign csum_expected = 7'(7'd0 - running_sum_reg);

    always_comb
    begin
        in_message_next    = in_message_reg;
        header_count_next  = header_count_reg;
        have_command_next  = have_command_reg;
        command_code_next  = command_code_reg;
        have_patch_next    = have_patch_reg;
        patch_held_next    = patch_held_reg;
        locked_port_next   = locked_port_reg;
        running_sum_next   = running_sum_reg;
        byte_count_next    = byte_count_reg;
        sent_checksum_next = sent_checksum_reg;
        emit               = 1'b0;
        item               = '0;
        item.reply_port    = port;
        expected           = {1'b0, device_id_reg};

        if (header_count_reg < HDR_LEN)
        begin
            expected = HDR_BYTES[header_count_reg];
        end

        // drop bytes from foreign ports while locked
        if (accept && !(in_message_reg && port != locked_port_reg))
        begin
            locked_port_next = port;
            if (!in_message_reg)
            begin
                if (b != expected)
                begin
                    header_count_next = 3'd0;
                    have_command_next = 1'b0;
                    command_code_next = 7'd0;
                    have_patch_next   = 1'b0;
                end
                else
                begin
                    header_count_next = header_count_reg + 3'd1;
                    if (header_count_reg == HDR_LEN)
                    begin
                        in_message_next = 1'b1;
                    end
                end
            end
            else if (b[7])
            begin
                if (b == SYSEX_END && have_command_reg)
                begin
                    item.event_kind = EV_REPLY;
                    priority if (command_code_reg == CMD_READ)
                    begin
                        emit = 1'b1;
                        if (!have_patch_reg)
                        begin
                            item.reply_status = ST_FEW;
                        end
                        else
                        begin
                            item.event_kind   = EV_DUMP;
                            item.patch_number = patch_held_reg;
                        end
                    end
                    else if (command_code_reg == CMD_WRITE)
                    begin
                        emit = 1'b1;
                        priority if (byte_count_reg < COUNT_W'(PATCH_BYTES + 1))
                            item.reply_status = ST_FEW;
                        else if (byte_count_reg > COUNT_W'(PATCH_BYTES + 1))
                            item.reply_status = ST_MANY;
                        else if (sent_checksum_reg != csum_expected)
                            item.reply_status = ST_CSUM;
                        else if (!store_ready_reg)
                            item.reply_status = ST_NOSTORE;
                        else
                            item.reply_status = ST_OK;
                    end
                    else if (command_code_reg == CMD_PING)
                    begin
                        emit              = 1'b1;
                        item.reply_status = ST_OK;
                    end
                    else
                    begin
                        emit = 1'b0;
                    end
                end
                in_message_next   = 1'b0;
                header_count_next = 3'd0;
                have_command_next = 1'b0;
                command_code_next = 7'd0;
                have_patch_next   = 1'b0;
            end
            else if (!have_command_reg)
            begin
                have_command_next = 1'b1;
                command_code_next = b[6:0];
                if (b[6:0] == CMD_WRITE)
                begin
                    running_sum_next   = 7'd0;
                    byte_count_next    = '0;
                    sent_checksum_next = 7'd0;
                end
                else if (b[6:0] != CMD_READ && b[6:0] != CMD_PING)
                begin
                    emit              = 1'b1;
                    item.event_kind   = EV_REPLY;
                    item.reply_status = ST_BADCMD;
                    in_message_next   = 1'b0;
                    header_count_next = 3'd0;
                    have_command_next = 1'b0;
                    command_code_next = 7'd0;
                    have_patch_next   = 1'b0;
                end
            end
            else if (command_code_reg == CMD_READ || command_code_reg == CMD_WRITE)
            begin
                if (!have_patch_reg)
                begin
                    patch_held_next = b[6:0];
                    have_patch_next = 1'b1;
                end
                else if (command_code_reg == CMD_WRITE)
                begin
                    if (byte_count_reg < COUNT_W'(PATCH_BYTES))
                    begin
                        emit               = 1'b1;
                        item.event_kind    = EV_WRITE;
                        item.write_address = 8'(byte_count_reg);
                        item.write_data    = b[6:0];
                        item.reply_port    = 8'd0;
                        running_sum_next   = running_sum_reg + b[6:0];
                    end
                    else if (byte_count_reg == COUNT_W'(PATCH_BYTES))
                    begin
                        sent_checksum_next = b[6:0];
                    end
                    if (byte_count_reg < COUNT_W'(COUNT_MAX))
                    begin
                        byte_count_next = byte_count_reg + COUNT_W'(1);
                    end
                end
            end
        end

        // hold the result while the receiver stalls
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (byte_stream.ready)
        begin
            out_valid_next = emit;
            out_data_next  = item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg     <= 7'd0;
            store_ready_reg   <= 1'b1;
            in_message_reg    <= 1'b0;
            header_count_reg  <= 3'd0;
            have_command_reg  <= 1'b0;
            command_code_reg  <= 7'd0;
            have_patch_reg    <= 1'b0;
            patch_held_reg    <= 7'd0;
            locked_port_reg   <= 8'd0;
            running_sum_reg   <= 7'd0;
            byte_count_reg    <= '0;
            sent_checksum_reg <= 7'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DEVICE_ID:   device_id_reg   <= cfg_data;
                    CFG_STORE_READY: store_ready_reg <= cfg_data[0];
                    default:         device_id_reg   <= device_id_reg;
                endcase
            end
            in_message_reg    <= in_message_next;
            header_count_reg  <= header_count_next;
            have_command_reg  <= have_command_next;
            command_code_reg  <= command_code_next;
            have_patch_reg    <= have_patch_next;
            patch_held_reg    <= patch_held_next;
            locked_port_reg   <= locked_port_next;
            running_sum_reg   <= running_sum_next;
            byte_count_reg    <= byte_count_next;
            sent_checksum_reg <= sent_checksum_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `MSX_ASSERT_IMPL(a_cmd_in_msg, clk, rst_n, have_command_reg, in_message_reg)
    `MSX_ASSERT_IMPL(a_patch_after_cmd, clk, rst_n, have_patch_reg, have_command_reg)
    `MSX_ASSERT_IMPL(a_count_sat, clk, rst_n, 1'b1, byte_count_reg <= COUNT_W'(COUNT_MAX))
    `MSX_ASSERT_IMPL(a_write_fields, clk, rst_n,
        out_valid_reg && out_data_reg.event_kind == EV_WRITE,
        out_data_reg.reply_port == 8'd0 && out_data_reg.patch_number == 7'd0)
    `MSX_ASSERT_NEXT(a_msg_hdr, clk, rst_n, !in_message_reg && in_message_next,
        in_message_reg && header_count_reg == HDR_LEN + 3'd1)

endmodule

// ===== sim/tb.sv =====
// Testbench for the SysEx command parser: sends tagged MIDI bytes, predicts every
// memory write, reply and dump request in step with the input, and compares each field.
// Depends on msx_pkg, msx_in_if, msx_out_if and midi_sysex_command_parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import msx_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;
    localparam logic [6:0] BAD_CMD_LO = 7'h00;
    localparam logic [6:0] BAD_CMD_HI = 7'h7f;
    localparam logic [7:0] NOTE_ON    = 8'h90;
    localparam logic [7:0] RESET_BYTE = 8'hff;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_data;

    msx_in_if  byte_stream ();
    msx_out_if event_stream ();

    midi_sysex_command_parser dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_stream  (byte_stream),
        .event_stream (event_stream)
    );

    logic [6:0] cur_device_id = 7'd0;
    logic       cur_store_ready = 1'b1;
    logic       in_msg = 1'b0;
    logic [2:0] hdr_pos = '0;
    logic       got_cmd = 1'b0;
    logic [6:0] cmd = '0;
    logic       got_patch = 1'b0;
    logic [6:0] patch = '0;
    logic [7:0] lock_port = '0;
    logic [6:0] sum7 = '0;
    int         count = 0;
    logic [6:0] csum_rx = '0;

    out_item_t pending_events[$];

    bit idle_en = 1'b1;
    int foreign_pct = 0;
    int bytes_sent = 0;
    int error_count = 0;
    int n_writes = 0;
    int n_replies = 0;
    int n_dumps = 0;
    int stall_cycles = 0;
    int ready_hold = 0;

    always #10 clk = ~clk;

    function automatic void close_message();
        in_msg = 1'b0;
        hdr_pos = '0;
        got_cmd = 1'b0;
        cmd = '0;
        got_patch = 1'b0;
    endfunction

    function automatic out_item_t reply_event(input logic [2:0] status);
        out_item_t ev;
        ev = '0;
        ev.event_kind = EV_REPLY;
        ev.reply_status = status;
        ev.reply_port = lock_port;
        return ev;
    endfunction

    function automatic logic [2:0] write_status();
        if (count < PATCH_BYTES + 1)
            return ST_FEW;
        if (count > PATCH_BYTES + 1)
            return ST_MANY;
        if (csum_rx != 7'(7'd0 - sum7))
            return ST_CSUM;
        if (!cur_store_ready)
            return ST_NOSTORE;
        return ST_OK;
    endfunction

    function automatic void parse_byte(input logic [7:0] port, input logic [7:0] b);
        out_item_t ev;
        bit        fire;
        bit        hdr_ok;
        ev = '0;
        fire = 1'b0;
        if (!in_msg || port == lock_port)
        begin
            lock_port = port;
            if (!in_msg)
            begin
                if (hdr_pos < HDR_LEN)
                    hdr_ok = (b == HDR_BYTES[hdr_pos]);
                else
                    hdr_ok = (b == {1'b0, cur_device_id});
                if (!hdr_ok)
                    close_message();
                else
                begin
                    hdr_pos = hdr_pos + 3'd1;
                    in_msg = (hdr_pos > HDR_LEN);
                end
            end
            else if (b[7])
            begin
                if (b == SYSEX_END && got_cmd)
                begin
                    fire = 1'b1;
                    if (cmd == CMD_READ && got_patch)
                    begin
                        ev.event_kind = EV_DUMP;
                        ev.patch_number = patch;
                        ev.reply_port = lock_port;
                    end
                    else if (cmd == CMD_READ)
                        ev = reply_event(ST_FEW);
                    else if (cmd == CMD_WRITE)
                        ev = reply_event(write_status());
                    else if (cmd == CMD_PING)
                        ev = reply_event(ST_OK);
                    else
                        fire = 1'b0;
                end
                close_message();
            end
            else if (!got_cmd)
            begin
                got_cmd = 1'b1;
                cmd = b[6:0];
                if (cmd == CMD_WRITE)
                begin
                    sum7 = '0;
                    count = 0;
                    csum_rx = '0;
                end
                else if (cmd != CMD_READ && cmd != CMD_PING)
                begin
                    fire = 1'b1;
                    ev = reply_event(ST_BADCMD);
                    close_message();
                end
            end
            else if (!got_patch && (cmd == CMD_READ || cmd == CMD_WRITE))
            begin
                patch = b[6:0];
                got_patch = 1'b1;
            end
            else if (cmd == CMD_WRITE)
            begin
                if (count < PATCH_BYTES)
                begin
                    fire = 1'b1;
                    ev.event_kind = EV_WRITE;
                    ev.write_address = 8'(count);
                    ev.write_data = b[6:0];
                    sum7 = sum7 + b[6:0];
                end
                else if (count == PATCH_BYTES)
                    csum_rx = b[6:0];
                if (count < PATCH_BYTES + 2)
                    count++;
            end
        end
        if (fire)
            pending_events.push_back(ev);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (error_count < PRINT_LIMIT)
            $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    task automatic check_event(input out_item_t got);
        out_item_t want;
        if (pending_events.size() == 0)
            report_mismatch("event with nothing pending", '0, got);
        else
        begin
            want = pending_events.pop_front();
            if (got.event_kind != want.event_kind)
                report_mismatch("event_kind", want.event_kind, got.event_kind);
            if (got.write_address != want.write_address)
                report_mismatch("write_address", want.write_address, got.write_address);
            if (got.write_data != want.write_data)
                report_mismatch("write_data", want.write_data, got.write_data);
            if (got.reply_status != want.reply_status)
                report_mismatch("reply_status", want.reply_status, got.reply_status);
            if (got.patch_number != want.patch_number)
                report_mismatch("patch_number", want.patch_number, got.patch_number);
            if (got.reply_port != want.reply_port)
                report_mismatch("reply_port", want.reply_port, got.reply_port);
            if (want.event_kind == EV_WRITE)
                n_writes++;
            else if (want.event_kind == EV_REPLY)
                n_replies++;
            else
                n_dumps++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (event_stream.valid && event_stream.ready)
                check_event(event_stream.data);
            if (byte_stream.valid && byte_stream.ready)
                parse_byte(byte_stream.data.source_port, byte_stream.data.midi_byte);
            if ((event_stream.valid && event_stream.ready) ||
                (byte_stream.valid && byte_stream.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d events outstanding",
                         STALL_LIMIT, pending_events.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold > 0)
            ready_hold--;
        else if (idle_en && $urandom_range(0, 9) == 0)
            ready_hold = $urandom_range(1, 15);
        event_stream.ready <= (ready_hold == 0);
    end

    task automatic send_byte(input logic [7:0] port, input logic [7:0] b);
        int gap;
        gap = (idle_en && $urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            byte_stream.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        // hold valid high across back-to-back transfers
        @(negedge clk);
        byte_stream.valid <= 1'b1;
        byte_stream.data <= '{source_port: port, midi_byte: b};
        do
            @(posedge clk);
        while (!byte_stream.ready);
        bytes_sent++;
    endtask

    task automatic drain_events();
        @(negedge clk);
        byte_stream.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [6:0] value);
        drain_events();
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_ID)
            cur_device_id = value;
        else
            cur_store_ready = value[0];
    endtask

    task automatic send_body(input logic [7:0] port, input logic [7:0] b);
        if ($urandom_range(0, 99) < foreign_pct)
            send_byte(port ^ 8'($urandom_range(1, 255)), 8'($urandom));
        send_byte(port, b);
    endtask

    task automatic send_header(input logic [7:0] port, input logic [6:0] id);
        for (int i = 0; i < int'(HDR_LEN); i++)
            send_byte(port, HDR_BYTES[i]);
        send_byte(port, {1'b0, id});
    endtask

    task automatic send_command(input logic [7:0] port, input logic [6:0] code);
        send_header(port, cur_device_id);
        send_body(port, {1'b0, code});
    endtask

    task automatic send_end(input logic [7:0] port);
        if ($urandom_range(0, 9) != 0)
            send_body(port, SYSEX_END);
        else
            send_body(port, {1'b1, 7'($urandom)});
    endtask

    task automatic send_write(input logic [7:0] port, input int n_data, input bit with_sum,
                              input bit good_sum, input int n_tail);
        logic [6:0] total;
        logic [6:0] d;
        total = '0;
        send_command(port, CMD_WRITE);
        send_body(port, 8'($urandom_range(0, 127)));
        for (int i = 0; i < n_data; i++)
        begin
            d = (i == 0) ? 7'h7f : 7'($urandom);
            total = total + d;
            send_body(port, {1'b0, d});
        end
        if (with_sum)
            send_body(port, {1'b0, good_sum ? 7'(7'd0 - total)
                                            : 7'(7'd0 - total) ^ 7'($urandom_range(1, 127))});
        repeat (n_tail) send_body(port, 8'($urandom_range(0, 127)));
        send_body(port, SYSEX_END);
    endtask

    task automatic test_commands();
        send_command(8'h00, CMD_PING);
        send_byte(8'h00, SYSEX_END);
        send_command(8'hff, CMD_READ);
        send_byte(8'hff, 8'h7f);
        send_byte(8'hff, 8'h00);
        send_byte(8'hff, SYSEX_END);
        send_command(8'h5a, CMD_READ);
        send_byte(8'h5a, SYSEX_END);
        send_command(8'ha5, CMD_WRITE);
        send_byte(8'ha5, SYSEX_END);
        send_command(8'h33, BAD_CMD_LO);
        send_command(8'hcc, BAD_CMD_HI);
    endtask

    task automatic test_framing();
        // restart inside the header: the second start byte is dropped, not retried
        send_byte(8'h10, HDR_BYTES[0]);
        send_header(8'h10, cur_device_id);
        send_byte(8'h10, {1'b0, CMD_PING});
        send_byte(8'h10, SYSEX_END);
        send_header(8'h11, cur_device_id ^ 7'h01);
        send_byte(8'h11, {1'b0, CMD_PING});
        send_byte(8'h11, SYSEX_END);
        send_command(8'h12, CMD_PING);
        send_byte(8'h12, NOTE_ON);
        send_byte(8'h12, SYSEX_END);
        send_header(8'h13, cur_device_id);
        send_byte(8'h13, SYSEX_END);
        send_command(8'h14, CMD_READ);
        send_byte(8'h14, 8'h2a);
        send_byte(8'h14, RESET_BYTE);
        send_command(8'h15, CMD_PING);
        send_byte(8'h15, SYSEX_END);
    endtask

    task automatic test_port_lock();
        send_command(8'h07, CMD_READ);
        send_byte(8'h08, 8'h33);
        send_byte(8'h07, 8'h44);
        send_byte(8'h09, SYSEX_END);
        send_byte(8'h07, SYSEX_END);
        write_register(CFG_DEVICE_ID, 7'h7f);
        send_command(8'hfe, CMD_PING);
        send_byte(8'h80, SYSEX_END);
        send_byte(8'hfe, SYSEX_END);
    endtask

    task automatic test_write_patch();
        foreign_pct = 2;
        write_register(CFG_STORE_READY, 7'd1);
        send_write(8'h3c, PATCH_BYTES, 1'b1, 1'b1, 0);
        send_write(8'hc3, PATCH_BYTES, 1'b1, 1'b0, 0);
        send_write(8'h81, PATCH_BYTES, 1'b1, 1'b1, 3);
        send_write(8'h7e, PATCH_BYTES, 1'b0, 1'b0, 0);
        write_register(CFG_STORE_READY, 7'd0);
        send_write(8'h18, PATCH_BYTES, 1'b1, 1'b1, 0);
        write_register(CFG_STORE_READY, 7'd1);
        foreign_pct = 0;
    endtask

    task automatic send_random_message();
        logic [7:0] port;
        logic [6:0] code;
        int         pick;
        int         n;
        port = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            send_command(port, CMD_PING);
            repeat ($urandom_range(0, 2)) send_body(port, 8'($urandom_range(0, 127)));
            send_end(port);
        end
        else if (pick < 38)
        begin
            send_command(port, CMD_READ);
            repeat ($urandom_range(0, 3)) send_body(port, 8'($urandom_range(0, 127)));
            send_end(port);
        end
        else if (pick < 50)
        begin
            do
                code = 7'($urandom);
            while (code == CMD_READ || code == CMD_WRITE || code == CMD_PING);
            send_command(port, code);
        end
        else if (pick < 64)
            send_write(port, $urandom_range(0, 12), 1'b0, 1'b0, 0);
        else if (pick < 65)
            send_write(port, PATCH_BYTES, 1'b1, 1'($urandom), $urandom_range(0, 3));
        else if (pick < 80)
        begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                send_byte(port, HDR_BYTES[i]);
            if (n < 5)
                send_byte(port, HDR_BYTES[n] ^ 8'($urandom_range(1, 255)));
            else
                send_byte(port, {1'b0, cur_device_id ^ 7'($urandom_range(1, 127))});
            send_body(port, {1'b0, CMD_PING});
            send_body(port, SYSEX_END);
        end
        else
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 8'($urandom));
        if ($urandom_range(0, 19) == 0)
            drain_events();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_en = (phase < 3);
            foreign_pct = (phase == 1) ? 0 : 5;
            write_register(CFG_DEVICE_ID, (phase == 0) ? 7'h00 :
                                          (phase == 1) ? 7'h7f : 7'($urandom));
            write_register(CFG_STORE_READY, 7'($urandom_range(0, 1)));
            stop_at = bytes_sent + 60;
            while (bytes_sent < stop_at)
                send_random_message();
        end
    endtask

    initial
    begin
        byte_stream.valid = 1'b0;
        byte_stream.data = '0;
        event_stream.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DEVICE_ID;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_commands();
        test_framing();
        test_port_lock();
        test_write_patch();
        test_random_traffic();
        drain_events();
        repeat (4) @(posedge clk);
        $display("Sent %0d bytes: framing, port lock, every command and status, four settings",
                 bytes_sent);
        $display("Checked %0d memory writes, %0d replies and %0d dump requests",
                 n_writes, n_replies, n_dumps);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
